// ----- sv/wbit_pkg.sv -----
`default_nettype none

package wbit_pkg;

  localparam int FUNC_W = 3;
  localparam int DT_W   = 16;
  localparam int MS_W   = 23;
  localparam int MIN_W  = 7;
  localparam int CYC_W  = 4;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 3;
  localparam int MAXM_W = 8;

  localparam int MAX_MINUTES_DEF = 99;
  localparam int FOCUS_RST       = 25;
  localparam int SHORT_RST       = 5;
  localparam int LONG_RST        = 15;
  localparam int CYC_RST         = 4;
  localparam int SOUND_RST       = 1;
  localparam int CYC_MAX         = 8;
  localparam int MS_PER_MIN      = 60000;
  localparam int MS_PER_SEC      = 1000;
  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 3'd0,
    FN_KEY   = 3'd1,
    FN_RESET = 3'd2,
    FN_SKIP  = 3'd3,
    FN_APPLY = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    PH_FOCUS = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RS_IDLE  = 2'd0,
    RS_RUN   = 2'd1,
    RS_PAUSE = 2'd2,
    RS_DONE  = 2'd3
  } rs_e;

  typedef enum logic [2:0] {
    TN_NONE  = 3'd0,
    TN_START = 3'd1,
    TN_PAUSE = 3'd2,
    TN_TICK  = 3'd3,
    TN_DONE  = 3'd4
  } tone_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_FOCUS = 3'd0,
    CFG_SHORT = 3'd1,
    CFG_LONG  = 3'd2,
    CFG_CYC   = 3'd3,
    CFG_SOUND = 3'd4
  } cfg_e;

  typedef struct packed {
    logic  load_in;
    logic  tick_upd;
    logic  rs_we;
    rs_e   rs_val;
    logic  tone_we;
    tone_e tone_val;
    logic  cnt_inc;
    logic  begin_ph;
    logic  begin_next;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    rs_e               run_state;
    phase_e            phase;
    logic              mod_busy;
    logic              out_free;
  } sts_t;

  // Phase length for an already clamped minute count, saturated to the field width.
  function automatic logic [MS_W-1:0] min_to_ms(input logic [MAXM_W-1:0] m);
    logic [MS_W:0] prod;
    prod = (MS_W+1)'(m) * (MS_W+1)'(MS_PER_MIN);
    return (prod > (MS_W+1)'(MS_MAX)) ? MS_MAX : prod[MS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/wbit_mod_unit.sv -----
`default_nettype none

module wbit_mod_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [wbit_pkg::CNT_W-1:0]   dividend_i,
  input  wire logic [wbit_pkg::CYC_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic [wbit_pkg::CYC_W-1:0]        rem_o
);

  localparam int N     = wbit_pkg::CNT_W;
  localparam int W     = wbit_pkg::CYC_W;
  localparam int STP_W = $clog2(N);

  logic             busy_q, busy_d;
  logic [STP_W-1:0] step_q, step_d;
  logic [N-1:0]     num_q, num_d;
  logic [W-1:0]     den_q, den_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W:0]       trial;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[N-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[W-1:0];
      end
      num_d  = {num_q[N-2:0], 1'b0};
      step_d = step_q + STP_W'(1);
      if (step_q == STP_W'(N - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- sv/wbit_datapath.sv -----
`default_nettype none

module wbit_datapath #(
  parameter int MAX_MINUTES = wbit_pkg::MAX_MINUTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wbit_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [wbit_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic [wbit_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [wbit_pkg::DT_W-1:0]     elapsed_ms_i,
  input  wire logic                          out_stall_i,
  input  wire wbit_pkg::cmd_t                cmd_i,
  output wbit_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  output logic [1:0]                         phase_o,
  output logic [1:0]                         run_state_o,
  output logic [wbit_pkg::MS_W-1:0]          remain_ms_o,
  output logic [wbit_pkg::MS_W-1:0]          phase_total_ms_o,
  output logic [wbit_pkg::CNT_W-1:0]         sessions_done_o,
  output logic [2:0]                         tone_o
);

  localparam int MS_W   = wbit_pkg::MS_W;
  localparam int MIN_W  = wbit_pkg::MIN_W;
  localparam int CYC_W  = wbit_pkg::CYC_W;
  localparam int CNT_W  = wbit_pkg::CNT_W;
  localparam int MAXM_W = wbit_pkg::MAXM_W;
  localparam logic [MAXM_W-1:0] MAX_M = MAXM_W'(MAX_MINUTES);
  localparam logic [MAXM_W-1:0] RST_MIN =
    (wbit_pkg::FOCUS_RST > MAX_MINUTES) ? MAX_M : MAXM_W'(wbit_pkg::FOCUS_RST);
  localparam logic [MS_W-1:0] RST_MS = wbit_pkg::min_to_ms(RST_MIN);
  localparam logic [MS_W-1:0] SEC1 = MS_W'(wbit_pkg::MS_PER_SEC);
  localparam logic [MS_W-1:0] SEC2 = MS_W'(2 * wbit_pkg::MS_PER_SEC);
  localparam logic [MS_W-1:0] SEC3 = MS_W'(3 * wbit_pkg::MS_PER_SEC);

  logic [MIN_W-1:0] focus_min_q, short_min_q, long_min_q;
  logic [CYC_W-1:0] cyc_q;
  logic             sound_q;

  logic [wbit_pkg::FUNC_W-1:0] func_q;
  logic [wbit_pkg::DT_W-1:0]   dt_q;

  wbit_pkg::phase_e phase_q, phase_d;
  wbit_pkg::rs_e    rs_q, rs_d;
  wbit_pkg::tone_e  tone_q, tone_d;
  logic [MS_W-1:0]  rem_q, rem_d;
  logic [MS_W-1:0]  tot_q, tot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             out_valid_q;
  logic [1:0]       out_phase_q, out_rs_q;
  logic [2:0]       out_tone_q;
  logic [MS_W-1:0]  out_rem_q, out_tot_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic                 out_free;
  logic                 tick_ge;
  logic [MS_W-1:0]      tick_diff;
  logic                 tick_hit;
  logic [CYC_W-1:0]     cyc_eff;
  logic                 mod_busy;
  logic [CYC_W-1:0]     mod_rem;
  wbit_pkg::phase_e     new_phase;
  logic [MIN_W-1:0]     sel_min;
  logic [MAXM_W-1:0]    clamp_min;
  logic [MS_W-1:0]      phase_ms;

  wbit_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cnt_inc),
    .dividend_i (cnt_q + CNT_W'(1)),
    .divisor_i  (cyc_eff),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  always_comb begin
    if (cyc_q == '0) begin
      cyc_eff = CYC_W'(1);
    end else if (cyc_q > CYC_W'(wbit_pkg::CYC_MAX)) begin
      cyc_eff = CYC_W'(wbit_pkg::CYC_MAX);
    end else begin
      cyc_eff = cyc_q;
    end
  end

  // A tone sounds when the rounded-up second drops into the last three.
  always_comb begin
    tick_ge   = {{(MS_W - wbit_pkg::DT_W){1'b0}}, dt_q} >= rem_q;
    tick_diff = rem_q - MS_W'(dt_q);
    if (tick_diff <= SEC1) begin
      tick_hit = rem_q > SEC1;
    end else if (tick_diff <= SEC2) begin
      tick_hit = rem_q > SEC2;
    end else if (tick_diff <= SEC3) begin
      tick_hit = rem_q > SEC3;
    end else begin
      tick_hit = 1'b0;
    end
  end

  always_comb begin
    if (!cmd_i.begin_next) begin
      new_phase = phase_q;
    end else if (phase_q == wbit_pkg::PH_FOCUS) begin
      new_phase = (mod_rem == '0) ? wbit_pkg::PH_LONG : wbit_pkg::PH_SHORT;
    end else begin
      new_phase = wbit_pkg::PH_FOCUS;
    end
    case (new_phase)
      wbit_pkg::PH_SHORT: sel_min = short_min_q;
      wbit_pkg::PH_LONG:  sel_min = long_min_q;
      default:            sel_min = focus_min_q;
    endcase
    if (sel_min == '0) begin
      clamp_min = MAXM_W'(1);
    end else if (MAXM_W'(sel_min) > MAX_M) begin
      clamp_min = MAX_M;
    end else begin
      clamp_min = MAXM_W'(sel_min);
    end
    phase_ms = wbit_pkg::min_to_ms(clamp_min);
  end

  always_comb begin
    phase_d = phase_q;
    rs_d    = rs_q;
    tone_d  = tone_q;
    rem_d   = rem_q;
    tot_d   = tot_q;
    cnt_d   = cnt_q;
    if (cmd_i.load_in) begin
      tone_d = wbit_pkg::TN_NONE;
    end
    if (cmd_i.tone_we) begin
      tone_d = cmd_i.tone_val;
    end
    if (cmd_i.tick_upd) begin
      if (tick_ge) begin
        rem_d  = '0;
        rs_d   = wbit_pkg::RS_DONE;
        tone_d = wbit_pkg::TN_DONE;
      end else begin
        rem_d  = tick_diff;
        tone_d = tick_hit ? wbit_pkg::TN_TICK : wbit_pkg::TN_NONE;
      end
    end
    if (cmd_i.rs_we) begin
      rs_d = cmd_i.rs_val;
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.begin_ph) begin
      phase_d = new_phase;
      rem_d   = phase_ms;
      tot_d   = phase_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_min_q <= MIN_W'(wbit_pkg::FOCUS_RST);
      short_min_q <= MIN_W'(wbit_pkg::SHORT_RST);
      long_min_q  <= MIN_W'(wbit_pkg::LONG_RST);
      cyc_q       <= CYC_W'(wbit_pkg::CYC_RST);
      sound_q     <= 1'(wbit_pkg::SOUND_RST);
      phase_q     <= wbit_pkg::PH_FOCUS;
      rs_q        <= wbit_pkg::RS_IDLE;
      tone_q      <= wbit_pkg::TN_NONE;
      rem_q       <= RST_MS;
      tot_q       <= RST_MS;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wbit_pkg::CFG_FOCUS: focus_min_q <= cfg_data_i[MIN_W-1:0];
          wbit_pkg::CFG_SHORT: short_min_q <= cfg_data_i[MIN_W-1:0];
          wbit_pkg::CFG_LONG:  long_min_q  <= cfg_data_i[MIN_W-1:0];
          wbit_pkg::CFG_CYC:   cyc_q       <= cfg_data_i[CYC_W-1:0];
          wbit_pkg::CFG_SOUND: sound_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      phase_q <= phase_d;
      rs_q    <= rs_d;
      tone_q  <= tone_d;
      rem_q   <= rem_d;
      tot_q   <= tot_d;
      cnt_q   <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      dt_q   <= elapsed_ms_i;
    end
    if (cmd_i.out_load) begin
      out_phase_q <= phase_q;
      out_rs_q    <= rs_q;
      out_rem_q   <= rem_q;
      out_tot_q   <= tot_q;
      out_cnt_q   <= cnt_q;
      out_tone_q  <= sound_q ? tone_q : wbit_pkg::TN_NONE;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.func      = func_q;
    sts_o.run_state = rs_q;
    sts_o.phase     = phase_q;
    sts_o.mod_busy  = mod_busy;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = out_phase_q;
  assign run_state_o      = out_rs_q;
  assign remain_ms_o      = out_rem_q;
  assign phase_total_ms_o = out_tot_q;
  assign sessions_done_o  = out_cnt_q;
  assign tone_o           = out_tone_q;

endmodule

`default_nettype wire

// ----- sv/wbit_ctrl.sv -----
`default_nettype none

module wbit_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire wbit_pkg::sts_t sts_i,
  output wbit_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_BEGIN = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   next_q, next_d;
  logic   run_after_q, run_after_d;

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    run_after_d = run_after_q;
    cmd_o       = '0;
    cmd_o.rs_val   = wbit_pkg::RS_IDLE;
    cmd_o.tone_val = wbit_pkg::TN_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_WRITE;
        next_d      = 1'b0;
        run_after_d = 1'b0;
        unique case (sts_i.func)
          wbit_pkg::FN_TICK: begin
            cmd_o.tick_upd = (sts_i.run_state == wbit_pkg::RS_RUN);
          end
          wbit_pkg::FN_KEY: begin
            cmd_o.tone_we = 1'b1;
            if (sts_i.run_state == wbit_pkg::RS_RUN) begin
              cmd_o.rs_we    = 1'b1;
              cmd_o.rs_val   = wbit_pkg::RS_PAUSE;
              cmd_o.tone_val = wbit_pkg::TN_PAUSE;
            end else if (sts_i.run_state == wbit_pkg::RS_DONE) begin
              cmd_o.tone_val = wbit_pkg::TN_START;
              next_d         = 1'b1;
              run_after_d    = 1'b1;
              cmd_o.cnt_inc  = (sts_i.phase == wbit_pkg::PH_FOCUS);
              state_d = (sts_i.phase == wbit_pkg::PH_FOCUS) ? ST_MOD : ST_BEGIN;
            end else begin
              cmd_o.rs_we    = 1'b1;
              cmd_o.rs_val   = wbit_pkg::RS_RUN;
              cmd_o.tone_val = wbit_pkg::TN_START;
            end
          end
          wbit_pkg::FN_RESET: begin
            state_d = ST_BEGIN;
          end
          wbit_pkg::FN_SKIP: begin
            next_d        = 1'b1;
            cmd_o.cnt_inc = (sts_i.phase == wbit_pkg::PH_FOCUS);
            state_d = (sts_i.phase == wbit_pkg::PH_FOCUS) ? ST_MOD : ST_BEGIN;
          end
          wbit_pkg::FN_APPLY: begin
            cmd_o.tone_we  = 1'b1;
            cmd_o.tone_val = wbit_pkg::TN_START;
            if (sts_i.run_state == wbit_pkg::RS_IDLE) begin
              state_d = ST_BEGIN;
            end
          end
          default: ;
        endcase
      end
      ST_MOD: begin
        if (!sts_i.mod_busy) begin
          state_d = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        cmd_o.begin_ph   = 1'b1;
        cmd_o.begin_next = next_q;
        cmd_o.rs_we      = 1'b1;
        cmd_o.rs_val     = run_after_q ? wbit_pkg::RS_RUN : wbit_pkg::RS_IDLE;
        state_d          = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_q      <= 1'b0;
      run_after_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      run_after_q <= run_after_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/work_break_interval_timer.sv -----
`default_nettype none

// Focus and break countdown sequencer. Each input word (a tick with its elapsed
// milliseconds, a start/pause key, a reset, a skip or an apply-settings command)
// yields exactly one output word with the phase, run state, remaining and total
// milliseconds, the wrapping count of finished focus sessions and a tone request.
// A word passes the idle, execute and write states; one that restarts a phase also
// passes the begin state, and one leaving a focus phase waits first in the mod state
// while the bit-serial remainder unit picks a short or a long break. Input stalls
// until the word is in the output register. Minute and cycle writes act at phase
// start; the user must write registers only while idle, as nothing enforces it.
module work_break_interval_timer #(
  parameter int MAX_MINUTES = wbit_pkg::MAX_MINUTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wbit_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wbit_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [wbit_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [wbit_pkg::DT_W-1:0]    elapsed_ms_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        phase_o,
  output logic [1:0]                        run_state_o,
  output logic [wbit_pkg::MS_W-1:0]         remain_ms_o,
  output logic [wbit_pkg::MS_W-1:0]         phase_total_ms_o,
  output logic [wbit_pkg::CNT_W-1:0]        sessions_done_o,
  output logic [2:0]                        tone_o
);

  wbit_pkg::cmd_t cmd;
  wbit_pkg::sts_t sts;

  wbit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbit_datapath #(
    .MAX_MINUTES (MAX_MINUTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .phase_o          (phase_o),
    .run_state_o      (run_state_o),
    .remain_ms_o      (remain_ms_o),
    .phase_total_ms_o (phase_total_ms_o),
    .sessions_done_o  (sessions_done_o),
    .tone_o           (tone_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
  import wbit_pkg::*;

  typedef struct {
    phase_e           ph;
    rs_e              rs;
    logic [MS_W-1:0]  remain;
    logic [MS_W-1:0]  total;
    logic [CNT_W-1:0] done;
    tone_e            tone;
  } timer_word_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int WORDS_PER_SETTING = 42;
  localparam longint DT_MAX = (longint'(1) << DT_W) - 1;
  localparam logic [FUNC_W-1:0] FN_UNUSED = FUNC_W'(FN_APPLY) + FUNC_W'(1);
  localparam logic [IDX_W-1:0] CFG_UNUSED = IDX_W'(CFG_SOUND) + IDX_W'(1);

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [FUNC_W-1:0] func_i;
  logic [DT_W-1:0] elapsed_ms_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] phase_o;
  logic [1:0] run_state_o;
  logic [MS_W-1:0] remain_ms_o;
  logic [MS_W-1:0] phase_total_ms_o;
  logic [CNT_W-1:0] sessions_done_o;
  logic [2:0] tone_o;

  work_break_interval_timer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phase_o          (phase_o),
    .run_state_o      (run_state_o),
    .remain_ms_o      (remain_ms_o),
    .phase_total_ms_o (phase_total_ms_o),
    .sessions_done_o  (sessions_done_o),
    .tone_o           (tone_o)
  );

  always #6 clk_i = ~clk_i;

  logic [MIN_W-1:0] focus_min;
  logic [MIN_W-1:0] short_min;
  logic [MIN_W-1:0] long_min;
  logic [CYC_W-1:0] cycle_len;
  logic sound_en;
  phase_e cur_ph;
  rs_e cur_rs;
  logic [MS_W-1:0] rem_ms;
  logic [MS_W-1:0] tot_ms;
  logic [CNT_W-1:0] focus_cnt;

  timer_word_t expected_words[$];
  timer_word_t exp_w;
  int n_err;
  int n_sent;
  int n_checked;
  int n_settings;
  int src_idle_pct;
  int snk_stall_pct;
  int quiet_cycles;

  function automatic logic [MS_W-1:0] phase_len(input logic [MIN_W-1:0] m);
    int mins;
    longint ms;
    mins = (m == 0) ? 1 : (m > MAX_MINUTES_DEF) ? MAX_MINUTES_DEF : int'(m);
    ms = longint'(mins) * MS_PER_MIN;
    return (ms > longint'(MS_MAX)) ? MS_MAX : MS_W'(ms);
  endfunction

  function automatic void load_phase(input phase_e p);
    cur_ph = p;
    if (p == PH_SHORT) begin
      tot_ms = phase_len(short_min);
    end else if (p == PH_LONG) begin
      tot_ms = phase_len(long_min);
    end else begin
      tot_ms = phase_len(focus_min);
    end
    rem_ms = tot_ms;
    cur_rs = RS_IDLE;
  endfunction

  function automatic void move_on();
    int cyc;
    if (cur_ph == PH_FOCUS) begin
      focus_cnt = focus_cnt + 1'b1;
      cyc = (cycle_len == 0) ? 1 : (cycle_len > CYC_MAX) ? CYC_MAX : int'(cycle_len);
      load_phase(((int'(focus_cnt) % cyc) == 0) ? PH_LONG : PH_SHORT);
    end else begin
      load_phase(PH_FOCUS);
    end
  endfunction

  function automatic timer_word_t predict_word(input logic [FUNC_W-1:0] f,
                                               input logic [DT_W-1:0] dt);
    timer_word_t w;
    tone_e tn;
    int secs_was;
    int secs_now;
    tn = TN_NONE;
    case (f)
      FN_TICK: begin
        if (cur_rs == RS_RUN) begin
          if (dt >= rem_ms) begin
            rem_ms = '0;
            cur_rs = RS_DONE;
            tn = TN_DONE;
          end else begin
            secs_was = (int'(rem_ms) + MS_PER_SEC - 1) / MS_PER_SEC;
            rem_ms = rem_ms - dt;
            secs_now = (int'(rem_ms) + MS_PER_SEC - 1) / MS_PER_SEC;
            if (secs_now != secs_was && secs_now >= 1 && secs_now <= 3) tn = TN_TICK;
          end
        end
      end
      FN_KEY: begin
        if (cur_rs == RS_IDLE || cur_rs == RS_PAUSE) begin
          cur_rs = RS_RUN;
          tn = TN_START;
        end else if (cur_rs == RS_RUN) begin
          cur_rs = RS_PAUSE;
          tn = TN_PAUSE;
        end else begin
          move_on();
          cur_rs = RS_RUN;
          tn = TN_START;
        end
      end
      FN_RESET: load_phase(cur_ph);
      FN_SKIP: move_on();
      FN_APPLY: begin
        if (cur_rs == RS_IDLE) load_phase(cur_ph);
        tn = TN_START;
      end
      default: ;
    endcase
    if (!sound_en) tn = TN_NONE;
    w.ph = cur_ph;
    w.rs = cur_rs;
    w.remain = rem_ms;
    w.total = tot_ms;
    w.done = focus_cnt;
    w.tone = tn;
    return w;
  endfunction

  function automatic void note_error(input string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        note_error("output word with no word expected");
      end else begin
        exp_w = expected_words.pop_front();
        n_checked++;
        if (phase_o !== exp_w.ph || run_state_o !== exp_w.rs ||
            remain_ms_o !== exp_w.remain || phase_total_ms_o !== exp_w.total ||
            sessions_done_o !== exp_w.done || tone_o !== exp_w.tone) begin
          note_error($sformatf({"word %0d: expected phase %0d run %0d remain %0d total %0d ",
                                "done %0d tone %0d, got %0d %0d %0d %0d %0d %0d"},
                               n_checked, exp_w.ph, exp_w.rs, exp_w.remain, exp_w.total,
                               exp_w.done, exp_w.tone, phase_o, run_state_o, remain_ms_o,
                               phase_total_ms_o, sessions_done_o, tone_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [DT_W-1:0] dt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    elapsed_ms_i <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(predict_word(f, dt));
    n_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_FOCUS: focus_min = data[MIN_W-1:0];
      CFG_SHORT: short_min = data[MIN_W-1:0];
      CFG_LONG: long_min = data[MIN_W-1:0];
      CFG_CYC: cycle_len = data[CYC_W-1:0];
      CFG_SOUND: sound_en = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [MIN_W-1:0] f, input logic [MIN_W-1:0] s,
                                input logic [MIN_W-1:0] l, input logic [CYC_W-1:0] c,
                                input logic snd);
    settle();
    if ($urandom_range(1) == 1) begin
      cfg_write(CFG_UNUSED + IDX_W'($urandom_range(0, 2)), CFG_W'($urandom));
    end
    cfg_write(CFG_FOCUS, CFG_W'(f));
    cfg_write(CFG_SHORT, CFG_W'(s));
    cfg_write(CFG_LONG, CFG_W'(l));
    cfg_write(CFG_CYC, CFG_W'(c));
    cfg_write(CFG_SOUND, {{(CFG_W-1){1'b0}}, snd});
    n_settings++;
  endtask

  function automatic logic [MIN_W-1:0] pick_minutes();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {MIN_W{1'b1}};
      2: return MIN_W'(MAX_MINUTES_DEF);
      3: return MIN_W'($urandom_range(MAX_MINUTES_DEF + 1, 126));
      default: return MIN_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [CYC_W-1:0] pick_cycle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {CYC_W{1'b1}};
      2: return CYC_W'(CYC_MAX);
      3: return CYC_W'($urandom_range(CYC_MAX + 1, 14));
      default: return CYC_W'($urandom_range(1, 5));
    endcase
  endfunction

  // Commands follow the run state most of the time so that phases actually
  // run out, with ticks aimed at the last few seconds of the countdown.
  task automatic random_word(output bit useful);
    logic [FUNC_W-1:0] f;
    logic [DT_W-1:0] dt;
    int pick;
    longint aim;
    dt = DT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      f = FUNC_W'($urandom_range(0, 7));
    end else begin
      case (cur_rs)
        RS_RUN: begin
          if (pick < 82) begin
            f = FN_TICK;
            case ($urandom_range(0, 2))
              0: ;
              1: begin
                aim = longint'(rem_ms) - longint'($urandom_range(0, 4000));
                if (aim < 0) dt = DT_W'($urandom_range(0, 1500));
                else if (aim > DT_MAX) dt = '1;
                else dt = DT_W'(aim);
              end
              default: dt = DT_W'($urandom_range(0, 1500));
            endcase
          end else if (pick < 88) f = FN_KEY;
          else if (pick < 92) f = FN_SKIP;
          else if (pick < 96) f = FN_RESET;
          else f = FN_APPLY;
        end
        RS_DONE: begin
          if (pick < 70) f = FN_KEY;
          else if (pick < 80) f = FN_SKIP;
          else if (pick < 88) f = FN_RESET;
          else if (pick < 94) f = FN_APPLY;
          else f = FN_TICK;
        end
        default: begin
          if (pick < 75) f = FN_KEY;
          else if (pick < 82) f = FN_SKIP;
          else if (pick < 88) f = FN_RESET;
          else if (pick < 94) f = FN_APPLY;
          else f = FN_TICK;
        end
      endcase
    end
    useful = (f <= FN_APPLY) && !(f == FN_TICK && cur_rs != RS_RUN);
    send_word(f, dt);
  endtask

  task automatic test_power_on();
    send_word(FN_TICK, '1);
    send_word(FN_UNUSED, DT_W'($urandom));
    send_word(FN_UNUSED + FUNC_W'(1), DT_W'($urandom));
    send_word(FN_UNUSED + FUNC_W'(2), DT_W'($urandom));
    send_word(FN_KEY, '0);
    send_word(FN_TICK, '0);
    send_word(FN_TICK, '1);
    send_word(FN_KEY, '0);
    send_word(FN_TICK, DT_W'(1000));
    send_word(FN_KEY, '0);
    send_word(FN_APPLY, '0);
    send_word(FN_RESET, '0);
    send_word(FN_APPLY, '0);
    send_word(FN_SKIP, '0);
    send_word(FN_SKIP, '0);
  endtask

  task automatic test_countdown();
    apply_settings(MIN_W'(1), MIN_W'(1), MIN_W'(1), CYC_W'(2), 1'b1);
    send_word(FN_RESET, '0);
    send_word(FN_KEY, '0);
    send_word(FN_TICK, DT_W'(56500));
    send_word(FN_TICK, DT_W'(500));
    send_word(FN_TICK, DT_W'(999));
    send_word(FN_TICK, DT_W'(1));
    send_word(FN_TICK, '1);
    send_word(FN_TICK, DT_W'(7));
    send_word(FN_KEY, '0);
    send_word(FN_SKIP, '0);
  endtask

  task automatic test_random(input int src_pct, input int snk_pct);
    bit useful;
    int n_useful;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (4) begin
      apply_settings(pick_minutes(), pick_minutes(), pick_minutes(), pick_cycle(),
                     ($urandom_range(0, 4) != 0));
      n_useful = 0;
      while (n_useful < WORDS_PER_SETTING) begin
        random_word(useful);
        if (useful) n_useful++;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    func_i <= FN_TICK;
    elapsed_ms_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_FOCUS;
    cfg_data_i <= '0;
    out_stall_i <= 1'b0;
    focus_min = MIN_W'(FOCUS_RST);
    short_min = MIN_W'(SHORT_RST);
    long_min = MIN_W'(LONG_RST);
    cycle_len = CYC_W'(CYC_RST);
    sound_en = 1'(SOUND_RST);
    focus_cnt = '0;
    load_phase(PH_FOCUS);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 9;
    snk_stall_pct = 71;
    test_power_on();
    test_countdown();
    test_random(9, 71);
    test_random(71, 9);
    test_random(0, 0);
    settle();

    if (expected_words.size() != 0) begin
      note_error($sformatf("%0d expected words never arrived", expected_words.size()));
    end
    $display("Sent %0d command words under %0d register settings; %0d results checked.",
             n_sent, n_settings, n_checked);
    $display("Covered all commands, countdowns to completion and unused codes; %0d errors.",
             n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
